[rtl/core/edt_pkg.sv]
package edt_pkg;

  localparam int SECS_W      = 32;
  localparam int OFS_W       = 17;
  localparam int PROD_W      = 2 * SECS_W;
  localparam int PC_W        = 4;
  localparam int DAYS_W      = 16;

  localparam logic [5:0]        DIV_MIN     = 6'd60;
  localparam logic [5:0]        DIV_HR      = 6'd24;
  localparam logic [SECS_W-1:0] RECIP_MIN   = 32'h8888_8889;
  localparam logic [SECS_W-1:0] RECIP_HR    = 32'hAAAA_AAAB;
  localparam int                SHIFT_MIN   = 37;
  localparam int                SHIFT_HR    = 36;
  localparam logic [11:0]       EPOCH_YEAR  = 12'd1970;
  localparam logic [1:0]        MOD4_INIT   = 2'd2;
  localparam logic [6:0]        MOD100_INIT = 7'd70;
  localparam logic [8:0]        MOD400_INIT = 9'd370;
  localparam logic [6:0]        MOD100_LAST = 7'd99;
  localparam logic [8:0]        MOD400_LAST = 9'd399;
  localparam logic [8:0]        DAYS_LEAP   = 9'd366;
  localparam logic [8:0]        DAYS_NORM   = 9'd365;
  localparam logic [4:0]        FEB_LEAP    = 5'd29;
  localparam logic [3:0]        MONTH_JAN   = 4'd1;
  localparam logic [3:0]        MONTH_FEB   = 4'd2;
  localparam logic [3:0]        MONTH_DEC   = 4'd12;

  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_IDLE = '0;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_MUL,
    OP_REM,
    OP_YEAR,
    OP_MONTH,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_WAIT,
    C_NEXT,
    C_YEAR,
    C_MONTH,
    C_ALWAYS
  } cond_t;

  typedef enum logic [1:0] {
    DST_SEC,
    DST_MIN,
    DST_HR
  } dst_t;

  typedef struct packed {
    op_t        op;
    cond_t      cond;
    dst_t       dst;
    logic [5:0] divisor;
    pc_t        target;
  } ucode_t;

  typedef struct packed {
    op_t        op;
    dst_t       dst;
    logic [5:0] divisor;
    logic       load;
  } ctrl_t;

  typedef struct packed {
    logic year_over;
    logic month_over;
  } stat_t;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[rtl/core/edt_ucode_rom.sv]
module edt_ucode_rom
  import edt_pkg::*;
(
  input  pc_t    pc,
  output ucode_t word
);

  always_comb begin
    case (pc)
      4'd0:    word = '{op: OP_IDLE,  cond: C_WAIT,   dst: DST_SEC, divisor: DIV_MIN,
                        target: 4'd0};
      4'd1:    word = '{op: OP_MUL,   cond: C_NEXT,   dst: DST_SEC, divisor: DIV_MIN,
                        target: 4'd0};
      4'd2:    word = '{op: OP_REM,   cond: C_NEXT,   dst: DST_SEC, divisor: DIV_MIN,
                        target: 4'd0};
      4'd3:    word = '{op: OP_MUL,   cond: C_NEXT,   dst: DST_MIN, divisor: DIV_MIN,
                        target: 4'd0};
      4'd4:    word = '{op: OP_REM,   cond: C_NEXT,   dst: DST_MIN, divisor: DIV_MIN,
                        target: 4'd0};
      4'd5:    word = '{op: OP_MUL,   cond: C_NEXT,   dst: DST_HR,  divisor: DIV_HR,
                        target: 4'd0};
      4'd6:    word = '{op: OP_REM,   cond: C_NEXT,   dst: DST_HR,  divisor: DIV_HR,
                        target: 4'd0};
      4'd7:    word = '{op: OP_YEAR,  cond: C_YEAR,   dst: DST_SEC, divisor: DIV_MIN,
                        target: 4'd7};
      4'd8:    word = '{op: OP_MONTH, cond: C_MONTH,  dst: DST_SEC, divisor: DIV_MIN,
                        target: 4'd8};
      4'd9:    word = '{op: OP_EMIT,  cond: C_ALWAYS, dst: DST_SEC, divisor: DIV_MIN,
                        target: 4'd0};
      default: word = '{op: OP_IDLE,  cond: C_ALWAYS, dst: DST_SEC, divisor: DIV_MIN,
                        target: 4'd0};
    endcase
  end

endmodule

[rtl/core/edt_seq.sv]
module edt_seq
  import edt_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  stat_t  stat,
  output ctrl_t  ctrl,
  output logic   busy,
  output logic   done
);

  pc_t    pc;
  pc_t    pc_next;
  ucode_t word;
  logic   jump;

  edt_ucode_rom u_rom (
    .pc   (pc),
    .word (word)
  );

  always_comb begin
    case (word.cond)
      C_WAIT:   jump = !start;
      C_NEXT:   jump = 1'b0;
      C_YEAR:   jump = stat.year_over;
      C_MONTH:  jump = stat.month_over;
      C_ALWAYS: jump = 1'b1;
      default:  jump = 1'b0;
    endcase
  end

  assign pc_next = jump ? word.target : pc + pc_t'(1);

  assign ctrl.op      = word.op;
  assign ctrl.dst     = word.dst;
  assign ctrl.divisor = word.divisor;
  assign ctrl.load    = (word.op == OP_IDLE) && start;

  assign busy = (pc != PC_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= PC_IDLE;
      done <= 1'b0;
    end else begin
      pc   <= pc_next;
      done <= (word.op == OP_EMIT);
    end
  end

endmodule

[rtl/core/edt_datapath.sv]
module edt_datapath
  import edt_pkg::*;
(
  input  logic              clk,
  input  ctrl_t             ctrl,
  input  logic [SECS_W-1:0] epoch_seconds,
  input  logic [OFS_W-1:0]  zone_offset,
  output stat_t             stat,
  output logic [11:0]       year,
  output logic [3:0]        month,
  output logic [4:0]        day,
  output logic [4:0]        hour,
  output logic [5:0]        minute,
  output logic [5:0]        second
);

  logic [SECS_W-1:0] num;
  logic [SECS_W-1:0] quot;
  logic [1:0]        mod4;
  logic [6:0]        mod100;
  logic [8:0]        mod400;

  logic [SECS_W-1:0] recip;
  logic [PROD_W-1:0] prod;
  logic [SECS_W-1:0] quot_calc;
  logic [5:0]        qd;
  logic [5:0]        rem;
  logic [SECS_W-1:0] sum;
  logic              leap;
  logic [8:0]        ylen;
  logic [4:0]        mlen;
  logic [DAYS_W-1:0] days;

  assign sum = epoch_seconds + {{(SECS_W-OFS_W){zone_offset[OFS_W-1]}}, zone_offset};

  // division by a constant: reciprocal multiply, remainder on the following step
  assign recip     = (ctrl.divisor == DIV_HR) ? RECIP_HR : RECIP_MIN;
  assign prod      = {{SECS_W{1'b0}}, num} * {{SECS_W{1'b0}}, recip};
  assign quot_calc = (ctrl.divisor == DIV_HR) ? SECS_W'(prod >> SHIFT_HR)
                                              : SECS_W'(prod >> SHIFT_MIN);
  assign qd        = quot[5:0] * ctrl.divisor;
  assign rem       = num[5:0] - qd;

  assign days = num[DAYS_W-1:0];
  assign leap = ((mod4 == 2'd0) && (mod100 != 7'd0)) || (mod400 == 9'd0);
  assign ylen = leap ? DAYS_LEAP : DAYS_NORM;
  assign mlen = (month == MONTH_FEB && leap) ? FEB_LEAP : month_len(month);

  assign stat.year_over  = (days >= {7'd0, ylen});
  assign stat.month_over = (days >= {11'd0, mlen}) && (month < MONTH_DEC);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      num    <= sum;
      year   <= EPOCH_YEAR;
      month  <= MONTH_JAN;
      mod4   <= MOD4_INIT;
      mod100 <= MOD100_INIT;
      mod400 <= MOD400_INIT;
    end else begin
      case (ctrl.op)
        OP_MUL: begin
          quot <= quot_calc;
        end
        OP_REM: begin
          num <= quot;
          case (ctrl.dst)
            DST_SEC: second <= rem;
            DST_MIN: minute <= rem;
            DST_HR:  hour   <= rem[4:0];
            default: second <= rem;
          endcase
        end
        OP_YEAR: begin
          if (stat.year_over) begin
            num    <= {{(SECS_W-DAYS_W){1'b0}}, days - {7'd0, ylen}};
            year   <= year + 12'd1;
            mod4   <= mod4 + 2'd1;
            mod100 <= (mod100 == MOD100_LAST) ? 7'd0 : mod100 + 7'd1;
            mod400 <= (mod400 == MOD400_LAST) ? 9'd0 : mod400 + 9'd1;
          end
        end
        OP_MONTH: begin
          if (stat.month_over) begin
            num   <= {{(SECS_W-DAYS_W){1'b0}}, days - {11'd0, mlen}};
            month <= month + 4'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign day = num[4:0] + 5'd1;

endmodule

[rtl/core/epoch_seconds_to_civil_date_top.sv]
// channel  direction  handshake                 payload
// input    in         start & !busy             epoch_seconds[31:0]
// result   out        done (one cycle)          year, month, day, hour, minute, second
// config   in         psel & penable & pwrite   zone_offset at byte address 0
//
// after the accept edge the sequencer runs the three divisions, each a reciprocal
// multiply step and a remainder step, then the year loop over Y years past 1970
// (0..136) and the month loop over M whole months (0..11), then raises done.
// the year and month loops step one year or one month per cycle of the sequencer.
// busy is high from the accept edge until done; a new item can start in the done cycle.
// rst is synchronous and clears the sequencer and zone_offset; results cannot be stalled.
module epoch_seconds_to_civil_date_top
  import edt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] epoch_seconds,
  output logic        busy,
  output logic        done,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [OFS_W-1:0] zone_offset;
  ctrl_t            ctrl;
  stat_t            stat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32-OFS_W){zone_offset[OFS_W-1]}}, zone_offset}
                                     : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_offset <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      zone_offset <= pwdata[OFS_W-1:0];
    end
  end

  edt_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy),
    .done  (done)
  );

  edt_datapath u_dp (
    .clk           (clk),
    .ctrl          (ctrl),
    .epoch_seconds (epoch_seconds),
    .zone_offset   (zone_offset),
    .stat          (stat),
    .year          (year),
    .month         (month),
    .day           (day),
    .hour          (hour),
    .minute        (minute),
    .second        (second)
  );

endmodule

[rtl/core/edt_checker.sv]
module edt_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [3:0] month,
  input logic [4:0] day
);

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while still busy");

  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (month >= 4'd1 && month <= 4'd12 && day >= 5'd1))
    else $error("month or day out of range");

endmodule

bind epoch_seconds_to_civil_date_top edt_checker u_chk (.*);

[sim/epoch_seconds_to_civil_date_top_tb.sv]
`timescale 1ns / 1ps

module epoch_seconds_to_civil_date_top_tb;
  import edt_pkg::*;

  localparam logic [2:0] ZONE_ADDR  = 3'd0;
  localparam logic [2:0] SPARE_ADDR = 3'd4;
  localparam int N_PHASES = 8;
  localparam int RAND_PER_PHASE = 250;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } civil_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [31:0] epoch_seconds = '0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic        busy;
  logic        done;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [31:0] prdata;
  logic        pready;

  logic [31:0]        pending_epochs[$];
  civil_t             due_dates[$];
  logic signed [16:0] zone_model = '0;
  int                 idle_left = 0;
  int                 accepted_cnt = 0;
  int                 checked_cnt = 0;
  int                 mismatches = 0;

  epoch_seconds_to_civil_date_top DUT (
    .clk, .rst, .start, .epoch_seconds, .busy, .done,
    .year, .month, .day, .hour, .minute, .second,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #10 clk = ~clk;

  function automatic bit yr_is_leap(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_days(int unsigned m, int unsigned y);
    int unsigned len;
    case (m)
      2:             len = yr_is_leap(y) ? 29 : 28;
      4, 6, 9, 11:   len = 30;
      default:       len = 31;
    endcase
    return len;
  endfunction

  function automatic civil_t civil_from_epoch(logic [31:0] epoch, logic signed [16:0] zone);
    logic [31:0] total;
    int unsigned secs, days, yr, mo, ylen, mlen;
    civil_t c;
    total = epoch + {{15{zone[16]}}, zone};
    secs = total;
    c.second = 6'(secs % 60);
    secs = secs / 60;
    c.minute = 6'(secs % 60);
    secs = secs / 60;
    c.hour = 5'(secs % 24);
    days = secs / 24;
    yr = 1970;
    ylen = yr_is_leap(yr) ? 366 : 365;
    while (days >= ylen) begin
      days -= ylen;
      yr++;
      ylen = yr_is_leap(yr) ? 366 : 365;
    end
    mo = 1;
    mlen = month_days(mo, yr);
    while (days >= mlen && mo < 12) begin
      days -= mlen;
      mo++;
      mlen = month_days(mo, yr);
    end
    c.year = 12'(yr);
    c.month = 4'(mo);
    c.day = 5'(days + 1);
    return c;
  endfunction

  // counts that land right around new year, leap day and the end of February after the offset
  function automatic logic [31:0] near_boundary(logic signed [16:0] zone);
    int unsigned y, d;
    int unsigned doy[5] = '{0, 58, 59, 364, 365};
    longint s;
    y = $urandom_range(1970, 2105);
    d = 0;
    for (int unsigned k = 1970; k < y; k++) d += yr_is_leap(k) ? 366 : 365;
    d += doy[$urandom_range(0, 4)];
    s = longint'(d) * 86400 - longint'(zone) + longint'($urandom_range(0, 4)) - 2;
    return s[31:0];
  endfunction

  function automatic logic [31:0] random_epoch(logic signed [16:0] zone);
    int unsigned pick;
    logic [31:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 50) v = $urandom;
    else if (pick < 85) v = near_boundary(zone);
    else if (pick < 93) v = $urandom_range(0, 200000);
    else v = 32'hFFFF_FFFF - $urandom_range(0, 200000);
    return v;
  endfunction

  function automatic void check_field(string name, int exp_val, int got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      mismatches++;
    end
  endfunction

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ZONE_ADDR) zone_model = data[16:0];
  endtask

  task automatic wait_idle();
    while (pending_epochs.size() != 0 || start || due_dates.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin : drive_items
    logic        go;
    logic [31:0] nxt;
    bit          quiet;
    go = start;
    nxt = epoch_seconds;
    quiet = accepted_cnt >= 600 && accepted_cnt < 1000;
    if (!rst) begin
      if (start && !busy) begin
        due_dates.push_back(civil_from_epoch(epoch_seconds, zone_model));
        accepted_cnt++;
        go = 1'b0;
      end
      if (!go) begin
        nxt = $urandom;
        if (idle_left > 0) begin
          // the gap only counts while the block could take an item
          if (!busy) idle_left--;
        end else if (pending_epochs.size() > 0) begin
          if (!quiet && $urandom_range(0, 99) < 12) begin
            idle_left = $urandom_range(0, 40);
          end else begin
            go = 1'b1;
            nxt = pending_epochs.pop_front();
          end
        end
      end
    end
    start <= go;
    epoch_seconds <= nxt;
  end

  always @(posedge clk) begin : check_dates
    civil_t exp_date;
    if (!rst && done) begin
      if (due_dates.size() == 0) begin
        $error("date result with no item outstanding");
        mismatches++;
      end else begin
        exp_date = due_dates.pop_front();
        checked_cnt++;
        check_field("year", exp_date.year, year);
        check_field("month", exp_date.month, month);
        check_field("day", exp_date.day, day);
        check_field("hour", exp_date.hour, hour);
        check_field("minute", exp_date.minute, minute);
        check_field("second", exp_date.second, second);
      end
    end
  end

  initial begin
    int zone_plan[N_PHASES];
    logic [31:0] directed[$];
    zone_plan = '{0, 50400, -50400, 65535, -65536, -1, 0, 0};
    zone_plan[6] = $urandom_range(0, 100800) - 50400;
    directed = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd86399,
                 32'd86400, 32'd68169600, 32'd68255999, 32'd951782400, 32'd978307199,
                 32'd978307200, 32'd4107456000, 32'd4107542400, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < N_PHASES; p++) begin
      if (p != 0) apb_write(ZONE_ADDR, 32'(zone_plan[p]));
      // writes past the register map must leave the offset alone
      if (p == 3) apb_write(SPARE_ADDR, 32'h0001_2345);
      if (p == 0) begin
        foreach (directed[i]) pending_epochs.push_back(directed[i]);
      end else begin
        pending_epochs.push_back(32'd0);
        pending_epochs.push_back(32'hFFFF_FFFF);
      end
      for (int i = 0; i < RAND_PER_PHASE; i++) pending_epochs.push_back(random_epoch(zone_model));
      wait_idle();
    end
    repeat (200) @(posedge clk);
    $display("%0d epoch counts converted and %0d dates checked over %0d zone offsets,",
             accepted_cnt, checked_cnt, N_PHASES);
    $display("including both offset extremes, wrap past zero and past the top of the count");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
